### sv/tcsp_pkg.sv
// Types, constants and step functions shared by the child sphere position pipeline.
// No dependencies.
`default_nettype none
package tcsp_pkg;

    localparam int CRD_W = 32;
    localparam int RAD_W = 30;
    localparam int ROOT_STEPS = 32;
    localparam int DIV_STEPS = 32;

    // Per-item data that travels alongside the arithmetic
    typedef struct packed {
        logic signed [CRD_W-1:0] p1x;
        logic signed [CRD_W-1:0] p1y;
        logic signed [CRD_W-1:0] p1z;
        logic signed [CRD_W-1:0] p2y;
        logic signed [CRD_W-1:0] mx;
        logic signed [CRD_W-1:0] my;
        logic signed [CRD_W-1:0] mz;
        logic [CRD_W-1:0]        ax;
        logic [CRD_W-1:0]        ay;
        logic [CRD_W-1:0]        az;
        logic                    sx;
        logic                    sy;
        logic                    sz;
        logic                    far;
        logic                    zero;
        logic                    pos;
    } side_t;

    // Digit-by-digit square root state: partial remainder, root, unconsumed radicand
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] val;
    } root_t;

    // Restoring divider state
    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] quo;
        logic [31:0] num;
        logic [32:0] den;
    } div_t;

    function automatic root_t root_step(root_t s);
        logic [35:0] rem_sh;
        logic [35:0] trial;
        root_t       n;
        rem_sh = {s.rem, s.val[63:62]};
        trial  = {2'b00, s.root, 2'b01};
        n.val  = {s.val[61:0], 2'b00};
        if (rem_sh >= trial)
        begin
            n.rem  = 34'(rem_sh - trial);
            n.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            n.rem  = rem_sh[33:0];
            n.root = {s.root[30:0], 1'b0};
        end
        return n;
    endfunction

    function automatic div_t div_step(div_t s);
        logic [33:0] rem_sh;
        div_t        n;
        rem_sh = {s.rem, s.num[31]};
        n.num  = {s.num[30:0], 1'b0};
        n.den  = s.den;
        if (rem_sh >= {1'b0, s.den})
        begin
            n.rem = 33'(rem_sh - {1'b0, s.den});
            n.quo = {s.quo[30:0], 1'b1};
        end
        else
        begin
            n.rem = rem_sh[32:0];
            n.quo = {s.quo[30:0], 1'b0};
        end
        return n;
    endfunction

    function automatic logic signed [CRD_W-1:0] sat32(logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -34'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage
`default_nettype wire

### sv/tcsp_if.sv
// Valid/ready channel interfaces for parent items and child results.
// Depends on tcsp_pkg for the coordinate width.
`default_nettype none
interface tcsp_in_if;
    logic valid;
    logic ready;
    logic signed [tcsp_pkg::CRD_W-1:0] first_x;
    logic signed [tcsp_pkg::CRD_W-1:0] first_y;
    logic signed [tcsp_pkg::CRD_W-1:0] first_z;
    logic signed [tcsp_pkg::CRD_W-1:0] second_x;
    logic signed [tcsp_pkg::CRD_W-1:0] second_y;
    logic signed [tcsp_pkg::CRD_W-1:0] second_z;
    logic signed [tcsp_pkg::CRD_W-1:0] normal_x;
    logic signed [tcsp_pkg::CRD_W-1:0] normal_z;
    modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                    normal_x, normal_z, input ready);
    modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  normal_x, normal_z, output ready);
endinterface

interface tcsp_out_if;
    logic valid;
    logic ready;
    logic signed [tcsp_pkg::CRD_W-1:0] child_x;
    logic signed [tcsp_pkg::CRD_W-1:0] child_y;
    logic signed [tcsp_pkg::CRD_W-1:0] child_z;
    logic used_midpoint;
    logic from_first_parent;
    modport source (output valid, child_x, child_y, child_z, used_midpoint, from_first_parent,
                    input ready);
    modport sink (input valid, child_x, child_y, child_z, used_midpoint, from_first_parent,
                  output ready);
endinterface
`default_nettype wire

### sv/tcsp_front.sv
// Front end: differences, midpoints, squares, cross test and range check (four stages).
// Depends on tcsp_pkg.
`default_nettype none
module tcsp_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              ce,
    input  wire logic                              in_vld,
    input  wire logic signed [tcsp_pkg::CRD_W-1:0] first_x,
    input  wire logic signed [tcsp_pkg::CRD_W-1:0] first_y,
    input  wire logic signed [tcsp_pkg::CRD_W-1:0] first_z,
    input  wire logic signed [tcsp_pkg::CRD_W-1:0] second_x,
    input  wire logic signed [tcsp_pkg::CRD_W-1:0] second_y,
    input  wire logic signed [tcsp_pkg::CRD_W-1:0] second_z,
    input  wire logic signed [tcsp_pkg::CRD_W-1:0] normal_x,
    input  wire logic signed [tcsp_pkg::CRD_W-1:0] normal_z,
    input  wire logic        [tcsp_pkg::RAD_W-1:0] radius,
    output tcsp_pkg::side_t                        side,
    output logic             [63:0]                d2,
    output logic             [63:0]                diff,
    output logic                                   out_vld
);
    logic signed [32:0] dx_w, dy_w, dz_w, smx_w, smy_w, smz_w;
    logic        [32:0] ax_w, ay_w, az_w;
    logic        [31:0] r4_w;
    tcsp_pkg::side_t    side_a_next;
    tcsp_pkg::side_t    side_c_next;
    tcsp_pkg::side_t    side_d_next;

    logic                    vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg;
    tcsp_pkg::side_t         side_a_reg, side_b_reg, side_c_reg, side_d_reg;
    logic                    big_a_reg, big_b_reg, big_c_reg;
    logic signed [31:0]      nx_a_reg, nz_a_reg;
    logic signed [32:0]      dx_a_reg, dz_a_reg;
    logic        [63:0]      ax2_b_reg, ay2_b_reg, az2_b_reg, r4sq_b_reg, r4sq_c_reg;
    logic signed [64:0]      cx_b_reg, cz_b_reg;
    logic        [65:0]      sum_c_reg;
    logic        [63:0]      d2_d_reg, diff_d_reg;

    always_comb
    begin
        dx_w  = 33'(first_x) - 33'(second_x);
        dy_w  = 33'(first_y) - 33'(second_y);
        dz_w  = 33'(first_z) - 33'(second_z);
        smx_w = 33'(first_x) + 33'(second_x);
        smy_w = 33'(first_y) + 33'(second_y);
        smz_w = 33'(first_z) + 33'(second_z);
        ax_w  = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
        ay_w  = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
        az_w  = dz_w[32] ? 33'(-dz_w) : 33'(dz_w);
        r4_w  = {radius, 2'b00};
        side_a_next      = '0;
        side_a_next.p1x  = first_x;
        side_a_next.p1y  = first_y;
        side_a_next.p1z  = first_z;
        side_a_next.p2y  = second_y;
        // floor of the half sum: drop the lowest bit of the widened sum
        side_a_next.mx   = smx_w[32:1];
        side_a_next.my   = smy_w[32:1];
        side_a_next.mz   = smz_w[32:1];
        side_a_next.ax   = ax_w[31:0];
        side_a_next.ay   = ay_w[31:0];
        side_a_next.az   = az_w[31:0];
        side_a_next.sx   = dx_w[32];
        side_a_next.sy   = dy_w[32];
        side_a_next.sz   = dz_w[32];
    end

    always_comb
    begin
        side_c_next      = side_b_reg;
        side_c_next.pos  = cx_b_reg < cz_b_reg;
        side_d_next      = side_c_reg;
        side_d_next.far  = big_c_reg || (sum_c_reg >= 66'(r4sq_c_reg));
        side_d_next.zero = sum_c_reg == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side_a_reg <= side_a_next;
            big_a_reg  <= ax_w[32] | ay_w[32] | az_w[32];
            nx_a_reg   <= normal_x;
            nz_a_reg   <= normal_z;
            dx_a_reg   <= dx_w;
            dz_a_reg   <= dz_w;

            side_b_reg <= side_a_reg;
            big_b_reg  <= big_a_reg;
            ax2_b_reg  <= 64'(side_a_reg.ax) * 64'(side_a_reg.ax);
            ay2_b_reg  <= 64'(side_a_reg.ay) * 64'(side_a_reg.ay);
            az2_b_reg  <= 64'(side_a_reg.az) * 64'(side_a_reg.az);
            r4sq_b_reg <= 64'(r4_w) * 64'(r4_w);
            cx_b_reg   <= 65'(dz_a_reg) * 65'(nx_a_reg);
            cz_b_reg   <= 65'(dx_a_reg) * 65'(nz_a_reg);

            side_c_reg     <= side_c_next;
            big_c_reg      <= big_b_reg;
            sum_c_reg      <= 66'(ax2_b_reg) + 66'(ay2_b_reg) + 66'(az2_b_reg);
            r4sq_c_reg     <= r4sq_b_reg;

            side_d_reg      <= side_d_next;
            d2_d_reg        <= sum_c_reg[63:0];
            diff_d_reg      <= r4sq_c_reg - sum_c_reg[63:0];
        end
    end

    assign side    = side_d_reg;
    assign d2      = d2_d_reg;
    assign diff    = diff_d_reg;
    assign out_vld = vld_d_reg;
endmodule
`default_nettype wire

### sv/tcsp_root.sv
// Two square roots side by side, one result bit per pipeline stage.
// Depends on tcsp_pkg.
`default_nettype none
module tcsp_root (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            ce,
    input  wire logic            in_vld,
    input  wire logic [63:0]     d2,
    input  wire logic [63:0]     diff,
    input  tcsp_pkg::side_t      side_in,
    output logic      [31:0]     d,
    output logic      [31:0]     q,
    output tcsp_pkg::side_t      side_out,
    output logic                 out_vld
);
    localparam int N = tcsp_pkg::ROOT_STEPS;

    tcsp_pkg::root_t ra_in [N];
    tcsp_pkg::root_t rb_in [N];
    tcsp_pkg::side_t sd_in [N];
    logic            vl_in [N];
    tcsp_pkg::root_t ra_reg [N];
    tcsp_pkg::root_t rb_reg [N];
    tcsp_pkg::side_t sd_reg [N];
    logic            vl_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        if (i == 0)
        begin : g_head
            assign ra_in[i] = '{rem: '0, root: '0, val: d2};
            assign rb_in[i] = '{rem: '0, root: '0, val: diff};
            assign sd_in[i] = side_in;
            assign vl_in[i] = in_vld;
        end
        else
        begin : g_body
            assign ra_in[i] = ra_reg[i-1];
            assign rb_in[i] = rb_reg[i-1];
            assign sd_in[i] = sd_reg[i-1];
            assign vl_in[i] = vl_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vl_reg[i] <= 1'b0;
            else if (ce)
                vl_reg[i] <= vl_in[i];
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                ra_reg[i] <= tcsp_pkg::root_step(ra_in[i]);
                rb_reg[i] <= tcsp_pkg::root_step(rb_in[i]);
                sd_reg[i] <= sd_in[i];
            end
        end
    end

    assign d        = ra_reg[N-1].root;
    assign q        = rb_reg[N-1].root;
    assign side_out = sd_reg[N-1];
    assign out_vld  = vl_reg[N-1];
endmodule
`default_nettype wire

### sv/tcsp_scale.sv
// Numerators and divisors for the three rounded quotients (two stages).
// Depends on tcsp_pkg.
`default_nettype none
module tcsp_scale (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        ce,
    input  wire logic                        in_vld,
    input  wire logic [31:0]                 d,
    input  wire logic [31:0]                 q,
    input  tcsp_pkg::side_t                  side_in,
    input  wire logic [tcsp_pkg::RAD_W-1:0]  radius,
    output tcsp_pkg::div_t                   ty_div,
    output tcsp_pkg::div_t                   kx_div,
    output tcsp_pkg::div_t                   kz_div,
    output tcsp_pkg::side_t                  side_out,
    output logic                             out_vld
);
    logic [64:0]     nty_w, nkx_w, nkz_w;
    logic            vld_e_reg, vld_f_reg;
    tcsp_pkg::side_t side_e_reg, side_f_reg;
    logic [62:0]     pty_e_reg;
    logic [63:0]     pkx_e_reg, pkz_e_reg;
    logic [31:0]     d_e_reg;
    tcsp_pkg::div_t  ty_f_reg, kx_f_reg, kz_f_reg;

    // round to nearest: add half the divisor before the floor division
    always_comb
    begin
        nty_w = 65'(pty_e_reg) + 65'(d_e_reg[31:1]);
        nkx_w = 65'(pkx_e_reg) + 65'(d_e_reg);
        nkz_w = 65'(pkz_e_reg) + 65'(d_e_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_e_reg <= in_vld;
            vld_f_reg <= vld_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            side_e_reg <= side_in;
            pty_e_reg  <= 63'({radius, 1'b0}) * 63'(side_in.ay);
            pkx_e_reg  <= 64'(q) * 64'(side_in.ax);
            pkz_e_reg  <= 64'(q) * 64'(side_in.az);
            d_e_reg    <= d;

            side_f_reg <= side_e_reg;
            ty_f_reg   <= '{rem: nty_w[64:32], quo: '0, num: nty_w[31:0], den: 33'(d_e_reg)};
            kx_f_reg   <= '{rem: nkx_w[64:32], quo: '0, num: nkx_w[31:0],
                            den: {d_e_reg, 1'b0}};
            kz_f_reg   <= '{rem: nkz_w[64:32], quo: '0, num: nkz_w[31:0],
                            den: {d_e_reg, 1'b0}};
        end
    end

    assign ty_div   = ty_f_reg;
    assign kx_div   = kx_f_reg;
    assign kz_div   = kz_f_reg;
    assign side_out = side_f_reg;
    assign out_vld  = vld_f_reg;
endmodule
`default_nettype wire

### sv/tcsp_divide.sv
// Three restoring dividers side by side, one quotient bit per pipeline stage.
// Depends on tcsp_pkg.
`default_nettype none
module tcsp_divide (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        ce,
    input  wire logic        in_vld,
    input  tcsp_pkg::div_t   ty_div,
    input  tcsp_pkg::div_t   kx_div,
    input  tcsp_pkg::div_t   kz_div,
    input  tcsp_pkg::side_t  side_in,
    output logic [31:0]      ty_mag,
    output logic [31:0]      kx_mag,
    output logic [31:0]      kz_mag,
    output tcsp_pkg::side_t  side_out,
    output logic             out_vld
);
    localparam int N = tcsp_pkg::DIV_STEPS;

    tcsp_pkg::div_t  ty_in [N];
    tcsp_pkg::div_t  kx_in [N];
    tcsp_pkg::div_t  kz_in [N];
    tcsp_pkg::side_t sd_in [N];
    logic            vl_in [N];
    tcsp_pkg::div_t  ty_reg [N];
    tcsp_pkg::div_t  kx_reg [N];
    tcsp_pkg::div_t  kz_reg [N];
    tcsp_pkg::side_t sd_reg [N];
    logic            vl_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        if (i == 0)
        begin : g_head
            assign ty_in[i] = ty_div;
            assign kx_in[i] = kx_div;
            assign kz_in[i] = kz_div;
            assign sd_in[i] = side_in;
            assign vl_in[i] = in_vld;
        end
        else
        begin : g_body
            assign ty_in[i] = ty_reg[i-1];
            assign kx_in[i] = kx_reg[i-1];
            assign kz_in[i] = kz_reg[i-1];
            assign sd_in[i] = sd_reg[i-1];
            assign vl_in[i] = vl_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vl_reg[i] <= 1'b0;
            else if (ce)
                vl_reg[i] <= vl_in[i];
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                ty_reg[i] <= tcsp_pkg::div_step(ty_in[i]);
                kx_reg[i] <= tcsp_pkg::div_step(kx_in[i]);
                kz_reg[i] <= tcsp_pkg::div_step(kz_in[i]);
                sd_reg[i] <= sd_in[i];
            end
        end
    end

    assign ty_mag   = ty_reg[N-1].quo;
    assign kx_mag   = kx_reg[N-1].quo;
    assign kz_mag   = kz_reg[N-1].quo;
    assign side_out = sd_reg[N-1];
    assign out_vld  = vl_reg[N-1];
endmodule
`default_nettype wire

### sv/tcsp_back.sv
// Final stage: apply signs, pick rotation and anchor, saturate into the output register.
// Depends on tcsp_pkg.
`default_nettype none
module tcsp_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              ce,
    input  wire logic                              in_vld,
    input  wire logic        [31:0]                ty_mag,
    input  wire logic        [31:0]                kx_mag,
    input  wire logic        [31:0]                kz_mag,
    input  tcsp_pkg::side_t                        side_in,
    output logic signed [tcsp_pkg::CRD_W-1:0]      child_x,
    output logic signed [tcsp_pkg::CRD_W-1:0]      child_y,
    output logic signed [tcsp_pkg::CRD_W-1:0]      child_z,
    output logic                                   used_midpoint,
    output logic                                   from_first_parent,
    output logic                                   out_vld
);
    logic signed [33:0] ty_w, kx_w, kz_w, x_w, y_w, z_w;
    logic signed [31:0] x_next, y_next, z_next;
    logic               mid_next, ff_next;
    logic               vld_reg;
    logic signed [31:0] x_reg, y_reg, z_reg;
    logic               mid_reg, ff_reg;

    always_comb
    begin
        ty_w = side_in.sy ? -34'(ty_mag) : 34'(ty_mag);
        kx_w = side_in.sx ? -34'(kx_mag) : 34'(kx_mag);
        kz_w = side_in.sz ? -34'(kz_mag) : 34'(kz_mag);
        if (side_in.pos)
        begin
            x_w = 34'(side_in.mx) - kz_w;
            y_w = 34'(side_in.p2y) + ty_w;
            z_w = 34'(side_in.mz) + kx_w;
        end
        else
        begin
            x_w = 34'(side_in.mx) + kz_w;
            y_w = 34'(side_in.p1y) + ty_w;
            z_w = 34'(side_in.mz) - kx_w;
        end
        if (side_in.far)
        begin
            x_next   = side_in.mx;
            y_next   = side_in.my;
            z_next   = side_in.mz;
            mid_next = 1'b1;
            ff_next  = 1'b0;
        end
        else if (side_in.zero)
        begin
            x_next   = side_in.p1x;
            y_next   = side_in.p1y;
            z_next   = side_in.p1z;
            mid_next = 1'b0;
            ff_next  = 1'b1;
        end
        else
        begin
            x_next   = tcsp_pkg::sat32(x_w);
            y_next   = tcsp_pkg::sat32(y_w);
            z_next   = tcsp_pkg::sat32(z_w);
            mid_next = 1'b0;
            ff_next  = !side_in.pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (ce)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            mid_reg <= mid_next;
            ff_reg  <= ff_next;
        end
    end

    assign child_x           = x_reg;
    assign child_y           = y_reg;
    assign child_z           = z_reg;
    assign used_midpoint     = mid_reg;
    assign from_first_parent = ff_reg;
    assign out_vld           = vld_reg;
endmodule
`default_nettype wire

### sv/tangent_child_sphere_position.sv
// Child sphere position: places a sphere touching two parent spheres.
// Parent pairs arrive on item_in (tcsp_in_if), results leave on child_out
// (tcsp_out_if); both are valid/ready channels, a transfer happens when both
// are high at a rising edge. The radius register is written with cfg_wr_en.
// Each input transfer passes through four front stages (differences,
// squares, range check), 32 square-root stages, two scaling stages, 32
// divider stages and the output register to result valid. One item is
// taken every cycle unless a stalled result holds the pipeline. Each
// square root and divider produces one bit per stage, which sets the depth.
// Reset clears every valid bit and sets the radius to 1.0; no item is in
// flight afterwards. When the receiver holds ready low with a result
// waiting, the whole pipeline holds, and item_in.ready drops in that cycle;
// nothing is lost or repeated.
// Depends on tcsp_pkg, tcsp_if and the tcsp_* stage modules.
`default_nettype none
module tangent_child_sphere_position #(
    parameter logic [29:0] RADIUS_RESET = 30'd65536
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    tcsp_in_if.sink                          item_in,
    tcsp_out_if.source                       child_out,
    input  wire logic                        cfg_wr_en,
    input  wire logic [tcsp_pkg::RAD_W-1:0]  cfg_wr_data
);
    logic                         ce;
    logic                         out_vld;
    logic [tcsp_pkg::RAD_W-1:0]   radius_reg;

    tcsp_pkg::side_t side_fr, side_rt, side_sc, side_dv;
    logic            vld_fr, vld_rt, vld_sc, vld_dv;
    logic [63:0]     d2, diff;
    logic [31:0]     d, q, ty_mag, kx_mag, kz_mag;
    tcsp_pkg::div_t  ty_div, kx_div, kz_div;

    // advance everything unless a finished result is stuck at the output
    assign ce            = !out_vld || child_out.ready;
    assign item_in.ready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else if (cfg_wr_en)
            radius_reg <= cfg_wr_data;
    end

    tcsp_front u_front (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(item_in.valid),
        .first_x(item_in.first_x), .first_y(item_in.first_y), .first_z(item_in.first_z),
        .second_x(item_in.second_x), .second_y(item_in.second_y),
        .second_z(item_in.second_z),
        .normal_x(item_in.normal_x), .normal_z(item_in.normal_z),
        .radius(radius_reg), .side(side_fr), .d2(d2), .diff(diff), .out_vld(vld_fr)
    );

    tcsp_root u_root (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(vld_fr), .d2(d2), .diff(diff),
        .side_in(side_fr), .d(d), .q(q), .side_out(side_rt), .out_vld(vld_rt)
    );

    tcsp_scale u_scale (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(vld_rt), .d(d), .q(q),
        .side_in(side_rt), .radius(radius_reg), .ty_div(ty_div), .kx_div(kx_div),
        .kz_div(kz_div), .side_out(side_sc), .out_vld(vld_sc)
    );

    tcsp_divide u_divide (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(vld_sc), .ty_div(ty_div),
        .kx_div(kx_div), .kz_div(kz_div), .side_in(side_sc), .ty_mag(ty_mag),
        .kx_mag(kx_mag), .kz_mag(kz_mag), .side_out(side_dv), .out_vld(vld_dv)
    );

    tcsp_back u_back (
        .clk(clk), .rst_n(rst_n), .ce(ce), .in_vld(vld_dv), .ty_mag(ty_mag),
        .kx_mag(kx_mag), .kz_mag(kz_mag), .side_in(side_dv),
        .child_x(child_out.child_x), .child_y(child_out.child_y),
        .child_z(child_out.child_z), .used_midpoint(child_out.used_midpoint),
        .from_first_parent(child_out.from_first_parent), .out_vld(out_vld)
    );

    assign child_out.valid = out_vld;
endmodule
`default_nettype wire

### sv/tcsp_checker.sv
// Port-level checks for the child sphere position block, bound to its top level.
// Depends on tangent_child_sphere_position and its channel interfaces.
`default_nettype none
module tcsp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] child_x,
    input wire logic [31:0] child_y,
    input wire logic [31:0] child_z,
    input wire logic        used_midpoint,
    input wire logic        from_first_parent
);
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    a_midpoint_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && used_midpoint |-> !from_first_parent)
        else $error("midpoint result marked as anchored at first parent");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(child_x) && $stable(child_y)
            && $stable(child_z) && $stable(used_midpoint) && $stable(from_first_parent))
        else $error("stalled result changed");
endmodule

bind tangent_child_sphere_position tcsp_checker u_tcsp_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(item_in.ready),
    .out_valid(child_out.valid),
    .out_ready(child_out.ready),
    .child_x(child_out.child_x),
    .child_y(child_out.child_y),
    .child_z(child_out.child_z),
    .used_midpoint(child_out.used_midpoint),
    .from_first_parent(child_out.from_first_parent)
);
`default_nettype wire

### test/tcsp_scoreboard.sv
// Scoreboard for the child sphere position block: predicts each child from an
// accepted parent pair and checks results in order. No dependencies.
`timescale 1ns / 100ps
class child_position_board;
    logic signed [31:0] pend_x[$];
    logic signed [31:0] pend_y[$];
    logic signed [31:0] pend_z[$];
    logic pend_mid[$];
    logic pend_first[$];
    logic [29:0] radius;
    int errors;

    function new();
        radius = 30'd65536;
        errors = 0;
    endfunction

    function void report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endfunction

    static function longint root64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    static function longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    static function longint rdiv(logic [63:0] num, logic [63:0] den, longint sgn);
        longint q;
        q = longint'((num + den / 2) / den);
        return sgn < 0 ? -q : q;
    endfunction

    // Note an accepted parent pair and queue the expected child
    function void note_pair(longint p1x, longint p1y, longint p1z, longint p2x,
                            longint p2y, longint p2z, longint nx, longint nz);
        longint dx, dy, dz, mx, my, mz, cx, cy, cz, ty, kx, kz;
        logic [63:0] ax, ay, az, r4, r4sq, d2, d, q;
        logic [64:0] s1;
        logic far, mid, first;
        dx = p1x - p2x;
        dy = p1y - p2y;
        dz = p1z - p2z;
        mx = (p1x + p2x) >>> 1;
        my = (p1y + p2y) >>> 1;
        mz = (p1z + p2z) >>> 1;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        az = dz < 0 ? -dz : dz;
        r4 = 64'(radius) * 4;
        r4sq = r4 * r4;
        far = ax[63:32] != 0 || ay[63:32] != 0 || az[63:32] != 0;
        d2 = 0;
        if (!far)
        begin
            s1 = 65'(ax * ax) + 65'(ay * ay) + 65'(az * az);
            d2 = s1[63:0];
            far = s1[64] || d2 >= r4sq;
        end
        mid = 0;
        first = 1;
        if (far)
        begin
            cx = mx; cy = my; cz = mz; mid = 1; first = 0;
        end
        else if (d2 == 0)
        begin
            cx = p1x; cy = p1y; cz = p1z;
        end
        else
        begin
            d = root64(d2);
            q = root64(r4sq - d2);
            ty = rdiv(64'(radius) * 2 * ay, d, dy);
            kx = rdiv(q * ax, d * 2, dx);
            kz = rdiv(q * az, d * 2, dz);
            if (dz * nx < dx * nz)
            begin
                cx = mx - kz; cy = p2y + ty; cz = mz + kx; first = 0;
            end
            else
            begin
                cx = mx + kz; cy = p1y + ty; cz = mz - kx;
            end
        end
        pend_x.push_back(32'(clip32(cx)));
        pend_y.push_back(32'(clip32(cy)));
        pend_z.push_back(32'(clip32(cz)));
        pend_mid.push_back(mid);
        pend_first.push_back(first);
    endfunction

    function void check_child(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, logic mid, logic first);
        logic signed [31:0] ex, ey, ez;
        logic em, ef;
        if (pend_x.size() == 0)
        begin
            report("unexpected result", 0, 0);
            return;
        end
        ex = pend_x.pop_front();
        ey = pend_y.pop_front();
        ez = pend_z.pop_front();
        em = pend_mid.pop_front();
        ef = pend_first.pop_front();
        if (x !== ex) report("child_x", x, ex);
        if (y !== ey) report("child_y", y, ey);
        if (z !== ez) report("child_z", z, ez);
        if (mid !== em) report("used_midpoint", mid, em);
        if (first !== ef) report("from_first_parent", first, ef);
    endfunction

    function int waiting();
        return pend_x.size();
    endfunction
endclass

### test/testbench.sv
// Top level of the child sphere position testbench: drives parent pairs and
// radius writes, stalls both channels at random. Depends on tcsp_pkg, tcsp_if,
// the block and tcsp_scoreboard.
`timescale 1ns / 100ps
module testbench;
    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wr_en = 0;
    logic [tcsp_pkg::RAD_W-1:0] cfg_wr_data = '0;
    logic calm = 0;
    child_position_board board;

    tcsp_in_if item_in();
    tcsp_out_if child_out();

    tangent_child_sphere_position dut (
        .clk(clk), .rst_n(rst_n), .item_in(item_in), .child_out(child_out),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        item_in.valid = 0;
        item_in.first_x = 0; item_in.first_y = 0; item_in.first_z = 0;
        item_in.second_x = 0; item_in.second_y = 0; item_in.second_z = 0;
        item_in.normal_x = 0; item_in.normal_z = 0;
        child_out.ready = 0;
    end

    // Note and check every transfer at the rising edge
    always @(posedge clk)
        if (rst_n)
        begin
            if (item_in.valid && item_in.ready)
                board.note_pair(item_in.first_x, item_in.first_y, item_in.first_z,
                    item_in.second_x, item_in.second_y, item_in.second_z,
                    item_in.normal_x, item_in.normal_z);
            if (child_out.valid && child_out.ready)
                board.check_child(child_out.child_x, child_out.child_y,
                    child_out.child_z, child_out.used_midpoint,
                    child_out.from_first_parent);
        end

    always @(negedge clk)
        child_out.ready <= calm || $urandom_range(99) >= 19;

    // Valid stays high after a transfer; the next call or the caller drops it
    task automatic send_pair(logic [31:0] ax, ay, az, bx, by, bz, nx, nz);
        while (!calm && $urandom_range(99) < 19)
        begin
            item_in.valid <= 0;
            @(negedge clk);
        end
        item_in.first_x <= ax; item_in.first_y <= ay; item_in.first_z <= az;
        item_in.second_x <= bx; item_in.second_y <= by; item_in.second_z <= bz;
        item_in.normal_x <= nx; item_in.normal_z <= nz;
        item_in.valid <= 1;
        @(posedge clk);
        while (!item_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_radius(logic [29:0] r);
        item_in.valid <= 0;
        while (board.waiting() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        cfg_wr_data <= r;
        cfg_wr_en <= 1;
        board.radius = r;
        @(negedge clk);
        cfg_wr_en <= 0;
    endtask

    function automatic logic [31:0] spread(logic [31:0] c, int span);
        return c + 32'($urandom_range(2 * span) - span);
    endfunction

    // Pairs mostly close enough for tangent placement, random content
    task automatic send_near();
        logic [31:0] bx, by, bz;
        int span;
        span = ($urandom_range(3) == 0) ? 32'h7fff_ffff : board.radius * 2 + 2;
        bx = $urandom(); by = $urandom(); bz = $urandom();
        if ($urandom_range(3) == 0)
        begin
            bx = {bx[31], {31{~bx[31]}}} ^ 32'($urandom_range(7));
            by = {by[31], {31{~by[31]}}} ^ 32'($urandom_range(7));
        end
        if (span > 32'h4000_0000) span = 32'h4000_0000;
        send_pair(spread(bx, span), spread(by, span), spread(bz, span), bx, by, bz,
                  $urandom(), $urandom());
    endtask

    initial
    begin
        logic [29:0] radii[6];
        board = new();
        radii = '{30'd65536, 30'd0, 30'h3fff_ffff, 30'd1, 30'd200000, 30'd3000};
        repeat (7) @(negedge clk);
        rst_n = 1;
        calm = 1;
        // extremes and special cases at the reset radius
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 1, 1);
        send_pair(32'h1_0000, 0, 0, 0, 0, 0, 0, 32'h1_0000);
        send_pair(32'h1_0000, 0, 0, 0, 0, 0, 0, 32'hffff_0000);
        send_pair(32'h1_0000, 0, 0, 0, 0, 0, 0, 0);
        send_pair(0, 32'h1_0000, 0, 0, 0, 0, 5, 5);
        send_pair(32'h7fff_ffff, 32'h7fff_0000, 32'h7fff_ffff, 32'h7fff_8000,
                  32'h7fff_0000, 32'h7fff_8000, 32'h8000_0000, 32'h7fff_ffff);
        send_pair(32'h8000_0000, 32'h8000_8000, 32'h8000_0000, 32'h8000_4000,
                  32'h8000_0000, 32'h8000_4000, 32'h7fff_ffff, 32'h8000_0000);
        send_pair(32'h4_0000, 0, 0, 0, 0, 0, 1, 1);
        send_pair(32'h3_ffff, 0, 0, 0, 0, 0, 1, 1);
        send_pair(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0,
                  32'hffff_ffff, 32'hffff_ffff);
        calm = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            set_radius(radii[ph]);
            // give one phase no idling at all
            calm = (ph == 4);
            send_pair(0, 32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 1, 0);
            send_pair(32'h10, 32'h20, 32'h30, 32'h10, 32'h20, 32'h30, 7, 9);
            for (int n = 0; n < 75; n++)
                if ($urandom_range(9) < 8)
                    send_near();
                else
                    send_pair($urandom(), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom(), $urandom(), $urandom());
            calm = 0;
        end
        calm = 1;
        item_in.valid <= 0;
        while (board.waiting() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        if (board.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end
endmodule

### filelist.f
sv/tcsp_pkg.sv
sv/tcsp_if.sv
sv/tcsp_front.sv
sv/tcsp_root.sv
sv/tcsp_scale.sv
sv/tcsp_divide.sv
sv/tcsp_back.sv
sv/tangent_child_sphere_position.sv
sv/tcsp_checker.sv
test/tcsp_scoreboard.sv
test/testbench.sv
